>>> rtl/core/acd_pkg.sv
// Shared types and constants of the actuator command decoder.
// No dependencies; imported by every module of the block.
package acd_pkg;

  localparam int unsigned DutyW     = 16;
  localparam int unsigned NumDuty   = 6;
  localparam int unsigned TicksW    = 8;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned StoredBytes = 5;
  localparam int unsigned ByteIdxW  = 3;

  // Slots of the duty vector, in output order
  localparam int unsigned DutyLeft   = 0;
  localparam int unsigned DutyRight  = 1;
  localparam int unsigned DutyDepo   = 2;
  localparam int unsigned DutyTilt   = 3;
  localparam int unsigned DutyChain  = 4;
  localparam int unsigned DutyHeight = 5;

  // Reset values of the configuration registers
  localparam logic [DutyW-1:0]  StopDutyRst    = 16'd2999;
  localparam logic [DutyW-1:0]  FullFwdDutyRst = 16'd3999;
  localparam logic [DutyW-1:0]  FullRevDutyRst = 16'd1999;
  localparam logic [DutyW-1:0]  HalfFwdDutyRst = 16'd3499;
  localparam logic [DutyW-1:0]  HalfRevDutyRst = 16'd2499;
  localparam logic [TicksW-1:0] TimeoutRst     = 8'd240;

  // Frame type bytes (ASCII '1' and '2')
  localparam logic [ByteW-1:0] TypeButtons  = 8'h31;
  localparam logic [ByteW-1:0] TypeJoystick = 8'h32;

  // Button codes
  localparam logic [ByteW-1:0] BtnChainRev   = 8'h80;
  localparam logic [ByteW-1:0] BtnHeightUp   = 8'h40;
  localparam logic [ByteW-1:0] BtnChainFwd   = 8'h20;
  localparam logic [ByteW-1:0] BtnHeightDn   = 8'h10;
  localparam logic [ByteW-1:0] BtnDepoFwd    = 8'h08;
  localparam logic [ByteW-1:0] BtnTiltFwd    = 8'h04;
  localparam logic [ByteW-1:0] BtnDepoRev    = 8'h02;
  localparam logic [ByteW-1:0] BtnTiltRev    = 8'h01;
  localparam logic [ByteW-1:0] BtnUpChainFwd = 8'h60;
  localparam logic [ByteW-1:0] BtnDnChainFwd = 8'h30;
  localparam logic [ByteW-1:0] BtnUpChainRev = 8'hC0;
  localparam logic [ByteW-1:0] BtnDnChainRev = 8'h90;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_STOP_DUTY     = 3'd0,
    CFG_FULL_FWD_DUTY = 3'd1,
    CFG_FULL_REV_DUTY = 3'd2,
    CFG_HALF_FWD_DUTY = 3'd3,
    CFG_HALF_REV_DUTY = 3'd4,
    CFG_TIMEOUT       = 3'd5
  } acd_cfg_idx_e;

  // Work item classes handed from front to back
  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_BYTE     = 3'd1,
    OP_BUTTONS  = 3'd2,
    OP_JOYSTICK = 3'd3,
    OP_OTHER    = 3'd4
  } acd_op_e;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_BUTTONS  = 2'd1,
    KIND_JOYSTICK = 2'd2,
    KIND_OTHER    = 2'd3
  } acd_kind_e;

  // Queue entry: class plus frame bytes 1..4 (index 0 = frame byte 1)
  typedef struct packed {
    logic [3:0][ByteW-1:0] bytes;
    acd_op_e               op;
  } acd_entry_t;

  typedef struct packed {
    logic [DutyW-1:0]  stop_duty;
    logic [DutyW-1:0]  full_fwd_duty;
    logic [DutyW-1:0]  full_rev_duty;
    logic [DutyW-1:0]  half_fwd_duty;
    logic [DutyW-1:0]  half_rev_duty;
    logic [TicksW-1:0] timeout_ticks;
  } acd_cfg_t;

endpackage

>>> rtl/core/actuator_command_decoder_unit.sv
// Top level of the actuator command decoder.
// Depends on acd_pkg, acd_front, acd_fifo and acd_back.

// Takes one transaction per cycle on the slave side while the queue has room:
// a received serial byte (tuser = 0) or a watchdog tick (tuser = 1). Bytes are
// gathered into frames of FRAME_LENGTH bytes; a completed frame of type '1' maps
// its button byte onto the deposit, excavator tilt, chain and height duties, a
// frame of type '2' loads the left and right drive duties from big-endian byte
// pairs, and any other type is reported but changes nothing. Frames of type '1'
// or '2' clear the watchdog; a tick that finds the counter at timeout_ticks sets
// all six duties to stop_duty and flags timed_out. Every transaction in produces
// exactly one transaction out carrying all six current duties.
// Throughput: the sustained rate is one transaction per cycle while the output
// is taken, bounded by the single duty/watchdog update the back end performs
// each cycle. The front end classifies each item combinationally into a
// QUEUE_DEPTH-entry queue, and the back end pops it from there into the result
// register once that register is free or being taken.
// The queue lets the input keep flowing while the output is stalled, until it
// holds QUEUE_DEPTH entries; s_axis_tready drops only when the queue is full.
// Configuration writes are always accepted (cfg_ready_o is tied high) and
// must only be issued while no transaction is outstanding.
module actuator_command_decoder_unit #(
  parameter int unsigned FRAME_LENGTH = 5,  // bytes per frame, 5..8
  parameter int unsigned QUEUE_DEPTH  = 4   // front-to-back queue entries
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [7:0] rx_byte
  input  logic                              s_axis_tuser,   // [0] cmd
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] left_drive, [31:16] right_drive, [47:32] deposit_tilt,
  // [63:48] digger_tilt, [79:64] digger_chain, [95:80] digger_height
  output logic [95:0]                       m_axis_tdata,
  output logic [2:0]                        m_axis_tuser,   // [1:0] frame_kind, [2] timed_out
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [acd_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [acd_pkg::DutyW-1:0]         cfg_data_i
);
  import acd_pkg::*;

  localparam int unsigned EntryW = $bits(acd_entry_t);

  acd_cfg_t   cfg_q;
  acd_entry_t push_entry, head_entry;
  logic [EntryW-1:0] head_bits;
  logic       push, pop, q_full, q_empty;
  logic       in_accept;
  acd_kind_e  kind;
  logic       timed_out;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !q_full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign head_entry    = acd_entry_t'(head_bits);
  assign m_axis_tuser  = {timed_out, kind};

  // Configuration registers; out-of-range indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_duty     <= StopDutyRst;
      cfg_q.full_fwd_duty <= FullFwdDutyRst;
      cfg_q.full_rev_duty <= FullRevDutyRst;
      cfg_q.half_fwd_duty <= HalfFwdDutyRst;
      cfg_q.half_rev_duty <= HalfRevDutyRst;
      cfg_q.timeout_ticks <= TimeoutRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_STOP_DUTY:     cfg_q.stop_duty     <= cfg_data_i;
        CFG_FULL_FWD_DUTY: cfg_q.full_fwd_duty <= cfg_data_i;
        CFG_FULL_REV_DUTY: cfg_q.full_rev_duty <= cfg_data_i;
        CFG_HALF_FWD_DUTY: cfg_q.half_fwd_duty <= cfg_data_i;
        CFG_HALF_REV_DUTY: cfg_q.half_rev_duty <= cfg_data_i;
        CFG_TIMEOUT:       cfg_q.timeout_ticks <= cfg_data_i[TicksW-1:0];
        default: ;
      endcase
    end
  end

  acd_front #(
    .FRAME_LENGTH (FRAME_LENGTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .cmd_i     (s_axis_tuser),
    .rx_byte_i (s_axis_tdata),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  acd_fifo #(
    .WIDTH (EntryW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (head_bits),
    .empty_o (q_empty)
  );

  acd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (q_empty),
    .entry_i     (head_entry),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .duty_o      (m_axis_tdata),
    .kind_o      (kind),
    .timed_out_o (timed_out)
  );

endmodule

>>> rtl/core/acd_front.sv
// Front end: accepts bytes and ticks, gathers frames and classifies each item.
// Depends on acd_pkg.
module acd_front #(
  parameter int unsigned FRAME_LENGTH = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic                      cmd_i,
  input  logic [7:0]                rx_byte_i,
  output logic                      push_o,
  output acd_pkg::acd_entry_t       entry_o
);
  import acd_pkg::*;

  localparam logic [ByteIdxW-1:0] LastIdx = ByteIdxW'(FRAME_LENGTH - 1);
  localparam logic [ByteIdxW-1:0] Byte4   = ByteIdxW'(4);

  logic [ByteIdxW-1:0] idx_q, idx_d;
  logic [ByteW-1:0]    frame_q [StoredBytes];
  logic                last_byte;
  logic [ByteW-1:0]    byte4;

  assign push_o    = accept_i;
  assign last_byte = (idx_q == LastIdx);
  // In a five-byte frame the closing byte is byte 4 itself
  assign byte4     = (idx_q == Byte4) ? rx_byte_i : frame_q[4];

  always_comb begin
    idx_d = idx_q;
    entry_o.op    = OP_BYTE;
    entry_o.bytes = '0;
    if (cmd_i) begin
      entry_o.op = OP_TICK;
    end else begin
      if (last_byte) begin
        idx_d = '0;
        entry_o.bytes = {byte4, frame_q[3], frame_q[2], frame_q[1]};
        if (frame_q[0] == TypeButtons) begin
          entry_o.op = OP_BUTTONS;
        end else if (frame_q[0] == TypeJoystick) begin
          entry_o.op = OP_JOYSTICK;
        end else begin
          entry_o.op = OP_OTHER;
        end
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (accept_i && !cmd_i) begin
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && !cmd_i && (idx_q < ByteIdxW'(StoredBytes))) begin
      frame_q[idx_q] <= rx_byte_i;
    end
  end

endmodule

>>> rtl/core/acd_fifo.sv
// Short flip-flop queue between front and back end.
// Depends on acd_pkg only for the shared import convention.
module acd_fifo #(
  parameter int unsigned WIDTH = 35,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  import acd_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH)) else $error("queue count beyond depth");

endmodule

>>> rtl/core/acd_back.sv
// Back end: executes queued items on the duty registers and the watchdog,
// and holds the result register. Depends on acd_pkg.
module acd_back (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  acd_pkg::acd_cfg_t                        cfg_i,
  input  logic                                     empty_i,
  input  acd_pkg::acd_entry_t                      entry_i,
  output logic                                     pop_o,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic [acd_pkg::NumDuty*acd_pkg::DutyW-1:0] duty_o,
  output acd_pkg::acd_kind_e                       kind_o,
  output logic                                     timed_out_o
);
  import acd_pkg::*;

  logic [NumDuty-1:0][DutyW-1:0] duty_q, duty_d;
  logic [TicksW-1:0]             idle_q, idle_d;
  acd_kind_e                     kind_q, kind_d;
  logic                          fired_q, fired_d;
  logic                          valid_q;
  logic                          slot_free;
  logic [ByteW-1:0]              buttons;

  // Duty registers double as the result payload: state only moves when the
  // result slot is free or being taken.
  assign slot_free   = !valid_q || out_ready_i;
  assign pop_o       = slot_free && !empty_i;
  assign buttons     = entry_i.bytes[0];
  assign out_valid_o = valid_q;
  assign duty_o      = duty_q;
  assign kind_o      = kind_q;
  assign timed_out_o = fired_q;

  always_comb begin
    duty_d  = duty_q;
    idle_d  = idle_q;
    kind_d  = kind_q;
    fired_d = fired_q;
    if (pop_o) begin
      kind_d  = KIND_NONE;
      fired_d = 1'b0;
      case (entry_i.op)
        OP_TICK: begin
          if (idle_q == cfg_i.timeout_ticks) begin
            duty_d  = {NumDuty{cfg_i.stop_duty}};
            idle_d  = TicksW'(1);
            fired_d = 1'b1;
          end else begin
            idle_d = idle_q + 1'b1;
          end
        end
        OP_BUTTONS: begin
          kind_d = KIND_BUTTONS;
          idle_d = '0;
          case (buttons)
            BtnChainRev: duty_d[DutyChain]  = cfg_i.full_rev_duty;
            BtnHeightUp: duty_d[DutyHeight] = cfg_i.half_fwd_duty;
            BtnChainFwd: duty_d[DutyChain]  = cfg_i.full_fwd_duty;
            BtnHeightDn: duty_d[DutyHeight] = cfg_i.half_rev_duty;
            BtnDepoFwd:  duty_d[DutyDepo]   = cfg_i.full_fwd_duty;
            BtnTiltFwd:  duty_d[DutyTilt]   = cfg_i.half_fwd_duty;
            BtnDepoRev:  duty_d[DutyDepo]   = cfg_i.full_rev_duty;
            BtnTiltRev:  duty_d[DutyTilt]   = cfg_i.half_rev_duty;
            BtnUpChainFwd: begin
              duty_d[DutyHeight] = cfg_i.half_fwd_duty;
              duty_d[DutyChain]  = cfg_i.half_fwd_duty;
            end
            BtnDnChainFwd: begin
              duty_d[DutyHeight] = cfg_i.half_rev_duty;
              duty_d[DutyChain]  = cfg_i.half_fwd_duty;
            end
            BtnUpChainRev: begin
              duty_d[DutyHeight] = cfg_i.half_fwd_duty;
              duty_d[DutyChain]  = cfg_i.half_rev_duty;
            end
            BtnDnChainRev: begin
              duty_d[DutyHeight] = cfg_i.half_rev_duty;
              duty_d[DutyChain]  = cfg_i.half_rev_duty;
            end
            default: begin
              // unknown combination: stop the four actuators, keep the drives
              duty_d[DutyDepo]   = cfg_i.stop_duty;
              duty_d[DutyTilt]   = cfg_i.stop_duty;
              duty_d[DutyChain]  = cfg_i.stop_duty;
              duty_d[DutyHeight] = cfg_i.stop_duty;
            end
          endcase
        end
        OP_JOYSTICK: begin
          kind_d = KIND_JOYSTICK;
          idle_d = '0;
          duty_d[DutyLeft]  = {entry_i.bytes[0], entry_i.bytes[1]};
          duty_d[DutyRight] = {entry_i.bytes[2], entry_i.bytes[3]};
        end
        OP_OTHER: kind_d = KIND_OTHER;
        OP_BYTE:  kind_d = KIND_NONE;
        default:  kind_d = KIND_NONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q  <= {NumDuty{StopDutyRst}};
      idle_q  <= '0;
      kind_q  <= KIND_NONE;
      fired_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      duty_q  <= duty_d;
      idle_q  <= idle_d;
      kind_q  <= kind_d;
      fired_q <= fired_d;
      if (pop_o) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  a_fire_no_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && fired_q) |-> (kind_q == KIND_NONE))
    else $error("watchdog stop reported together with a frame");
  a_fire_all_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && fired_q) |-> (duty_q[DutyLeft] == duty_q[DutyRight] &&
                              duty_q[DutyRight] == duty_q[DutyDepo] &&
                              duty_q[DutyDepo] == duty_q[DutyTilt] &&
                              duty_q[DutyTilt] == duty_q[DutyChain] &&
                              duty_q[DutyChain] == duty_q[DutyHeight]))
    else $error("watchdog stop left a duty unstopped");
  a_fire_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && entry_i.op == OP_TICK && idle_q == cfg_i.timeout_ticks)
      |=> (idle_q == TicksW'(1) && fired_q))
    else $error("watchdog counter did not restart after stop");

endmodule
